### rtl/core/pahc_pkg.sv
// Shared constants, codes and types of the pixel attractor hill-climb unit.
`timescale 1ns / 1ps

package pahc_pkg;

    // Default sizes of the stamp and of one sample.
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int MAX_HEIGHT_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Walk coordinates: a configured dimension is at most 127.
    localparam int COORD_W = 7;
    localparam int CFG_W   = 7;
    localparam int STEP_W  = 12;

    localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
    localparam logic [STEP_W-1:0] STEP_MAX  = 12'hFFF;

    // Input item commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes (byte address bit 2).
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Probe order of one step; the winning probe is also the move direction,
    // and the centre as winner means no move.
    typedef enum logic [2:0] {
        PRB_CENTRE = 3'd0,
        PRB_LEFT   = 3'd1,
        PRB_UP     = 3'd2,
        PRB_RIGHT  = 3'd3,
        PRB_DOWN   = 3'd4
    } t_probe;

    // Control of the compare unit for the sample that arrives from memory.
    typedef struct packed {
        logic   en;
        t_probe probe;
    } t_cmp_ctrl;

endpackage

### rtl/core/pahc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pahc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/pahc_cmp.sv
// Shared compare unit: ranks each probed sample against the best one of the step.
`timescale 1ns / 1ps

module pahc_cmp #(
    parameter int KEY_W = pahc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pahc_pkg::t_cmp_ctrl i_ctrl,
    input  logic [KEY_W-1:0]    i_key,
    output pahc_pkg::t_probe    o_dir
);

    logic [KEY_W-1:0] r_best;
    logic [KEY_W-1:0] n_best;
    pahc_pkg::t_probe r_dir;
    pahc_pkg::t_probe n_dir;
    logic             strict;
    logic             win;

    // Left and up need a strictly greater key; right and down win on a tie.
    always_comb begin
        strict = i_ctrl.probe inside {pahc_pkg::PRB_LEFT, pahc_pkg::PRB_UP};
        win    = strict ? (i_key > r_best) : (i_key >= r_best);
        n_best = r_best;
        n_dir  = r_dir;
        if (i_ctrl.en && (i_ctrl.probe == pahc_pkg::PRB_CENTRE || win)) begin
            n_best = i_key;
            n_dir  = i_ctrl.probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= pahc_pkg::PRB_CENTRE;
        end else begin
            r_dir <= n_dir;
        end
        r_best <= n_best;
    end

    assign o_dir = n_dir;

endmodule

### rtl/core/pixel_attractor_hill_climb_unit.sv
// Top level of the pixel attractor hill-climb unit: sequencer, stamp memory, ports.
`timescale 1ns / 1ps

// Load beats (cmd 0) write one sample into the stamp memory and produce no
// result; a load outside the configured stamp is dropped.
// Query beats (cmd 1) start a steepest-ascent walk from the named pixel: each
// move probes the centre and its left, up, right and down neighbours through
// the single read port of the stamp memory, one probe per cycle, while one
// shared comparator ranks the returning samples (left/up need a strictly
// greater sample, right/down win ties, down beats right). A move is five probe
// steps followed by one decide step; a query outside the stamp skips the walk
// and answers with bad_coord set and zero coordinates. The input is not ready
// while a walk runs. One finished result is held in an output register, so
// loads are taken while it waits; the next query's result waits for that
// register to drain. stamp_width and stamp_height are written over the
// APB-style port; the user must write them only while idle, as the block does
// not enforce it. 0 acts as 1 and values above the maximum clamp to it.
// step_count saturates at 4095. Samples are compared as signed integers; the
// memory has no reset and must be loaded before it is walked.
module pixel_attractor_hill_climb_unit #(
    parameter int MAX_WIDTH   = pahc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = pahc_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = pahc_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [5:0]         i_pos_x,
    input  logic [5:0]         i_pos_y,
    input  logic signed [31:0] i_sample,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_attr_x,
    output logic [5:0]         o_attr_y,
    output logic [11:0]        o_step_count,
    output logic               o_bad_coord
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = pahc_pkg::COORD_W;
    localparam logic [SAMPLE_BITS-1:0] SIGN_KEY = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PROBE  = 4'b0010,
        S_DECIDE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers and the effective stamp size.
    logic [pahc_pkg::CFG_W-1:0] r_cfg_w;
    logic [pahc_pkg::CFG_W-1:0] r_cfg_h;
    logic [CW-1:0]              w_eff;
    logic [CW-1:0]              h_eff;

    // Walk state.
    logic [CW-1:0]                  r_x;
    logic [CW-1:0]                  n_x;
    logic [CW-1:0]                  r_y;
    logic [CW-1:0]                  n_y;
    logic [pahc_pkg::STEP_W-1:0]    r_steps;
    logic [pahc_pkg::STEP_W-1:0]    n_steps;
    logic                           r_bad;
    logic                           n_bad;
    pahc_pkg::t_probe               r_probe;
    pahc_pkg::t_probe               n_probe;
    pahc_pkg::t_cmp_ctrl            r_pend;
    pahc_pkg::t_cmp_ctrl            n_pend;

    // Output register.
    logic                           r_out_valid;
    logic [5:0]                     r_attr_x;
    logic [5:0]                     r_attr_y;
    logic [pahc_pkg::STEP_W-1:0]    r_step_count;
    logic                           r_bad_coord;
    logic                           out_load;

    // Probe address generation.
    logic [CW-1:0]          prb_x;
    logic [CW-1:0]          prb_y;
    logic                   prb_ok;
    logic                   in_accept;
    logic                   pos_in;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   rd_en;
    logic [SAMPLE_BITS-1:0] load_key;
    logic [SAMPLE_BITS-1:0] rd_key;
    pahc_pkg::t_probe       cmp_dir;
    logic                   cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= pahc_pkg::CFG_RESET;
            r_cfg_h <= pahc_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                pahc_pkg::REG_WIDTH:  r_cfg_w <= pwdata[pahc_pkg::CFG_W-1:0];
                pahc_pkg::REG_HEIGHT: r_cfg_h <= pwdata[pahc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pahc_pkg::REG_WIDTH:  prdata = 32'(r_cfg_w);
            pahc_pkg::REG_HEIGHT: prdata = 32'(r_cfg_h);
            default:              prdata = '0;
        endcase
    end

    // Zero acts as one; anything above the maximum clamps to it.
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = CW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = CW'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_h;
        end
    end

    // ---------------- loads ----------------
    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign pos_in     = (CW'(i_pos_x) < w_eff) && (CW'(i_pos_y) < h_eff);
    assign wr_en      = in_accept && (i_cmd == pahc_pkg::CMD_LOAD) && pos_in;
    assign wr_addr    = AW'(32'(i_pos_y) * MAX_WIDTH + 32'(i_pos_x));
    // Wrap or sign-extend to the sample width, then flip the sign bit so an
    // unsigned compare orders the keys like signed samples.
    assign load_key   = SAMPLE_BITS'(i_sample) ^ SIGN_KEY;

    // ---------------- probe addressing ----------------
    always_comb begin
        prb_x  = r_x;
        prb_y  = r_y;
        prb_ok = 1'b0;
        case (r_probe)
            pahc_pkg::PRB_CENTRE: begin
                prb_ok = 1'b1;
            end
            pahc_pkg::PRB_LEFT: begin
                prb_x  = r_x - CW'(1);
                prb_ok = (r_x != '0);
            end
            pahc_pkg::PRB_UP: begin
                prb_y  = r_y - CW'(1);
                prb_ok = (r_y != '0);
            end
            pahc_pkg::PRB_RIGHT: begin
                prb_x  = r_x + CW'(1);
                prb_ok = ((CW+1)'(r_x) + (CW+1)'(1)) < (CW+1)'(w_eff);
            end
            pahc_pkg::PRB_DOWN: begin
                prb_y  = r_y + CW'(1);
                prb_ok = ((CW+1)'(r_y) + (CW+1)'(1)) < (CW+1)'(h_eff);
            end
            default: begin
                prb_ok = 1'b0;
            end
        endcase
    end

    assign rd_en   = (r_state == S_PROBE) && prb_ok;
    assign rd_addr = AW'(32'(prb_y) * MAX_WIDTH + 32'(prb_x));

    pahc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_stamp (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (load_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_key)
    );

    pahc_cmp #(
        .KEY_W (SAMPLE_BITS)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_pend),
        .i_key   (rd_key),
        .o_dir   (cmp_dir)
    );

    // ---------------- sequencer ----------------
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_y          = r_y;
        n_steps      = r_steps;
        n_bad        = r_bad;
        n_probe      = r_probe;
        n_pend.en    = 1'b0;
        n_pend.probe = r_probe;
        case (r_state)
            S_IDLE: begin
                if (in_accept && i_cmd == pahc_pkg::CMD_QUERY) begin
                    n_x     = CW'(i_pos_x);
                    n_y     = CW'(i_pos_y);
                    n_steps = '0;
                    n_probe = pahc_pkg::PRB_CENTRE;
                    n_bad   = !pos_in;
                    n_state = pos_in ? S_PROBE : S_DONE;
                end
            end
            S_PROBE: begin
                // Step one probe a cycle, reading only where it lies in the stamp; its sample is ranked on the next.
                n_pend.en = prb_ok;
                case (r_probe)
                    pahc_pkg::PRB_CENTRE: n_probe = pahc_pkg::PRB_LEFT;
                    pahc_pkg::PRB_LEFT:   n_probe = pahc_pkg::PRB_UP;
                    pahc_pkg::PRB_UP:     n_probe = pahc_pkg::PRB_RIGHT;
                    pahc_pkg::PRB_RIGHT:  n_probe = pahc_pkg::PRB_DOWN;
                    default: begin
                        n_probe = pahc_pkg::PRB_CENTRE;
                        n_state = S_DECIDE;
                    end
                endcase
            end
            S_DECIDE: begin
                // The down sample is ranked this cycle; move or stop.
                n_probe = pahc_pkg::PRB_CENTRE;
                case (cmp_dir)
                    pahc_pkg::PRB_LEFT:  n_x = r_x - CW'(1);
                    pahc_pkg::PRB_UP:    n_y = r_y - CW'(1);
                    pahc_pkg::PRB_RIGHT: n_x = r_x + CW'(1);
                    pahc_pkg::PRB_DOWN:  n_y = r_y + CW'(1);
                    default: ;
                endcase
                if (cmp_dir == pahc_pkg::PRB_CENTRE) begin
                    n_state = S_DONE;
                end else begin
                    if (r_steps != pahc_pkg::STEP_MAX) begin
                        n_steps = r_steps + pahc_pkg::STEP_W'(1);
                    end
                    n_state = S_PROBE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_x          <= '0;
            r_y          <= '0;
            r_steps      <= '0;
            r_bad        <= 1'b0;
            r_probe      <= pahc_pkg::PRB_CENTRE;
            r_pend.en    <= 1'b0;
            r_pend.probe <= pahc_pkg::PRB_CENTRE;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_steps <= n_steps;
            r_bad   <= n_bad;
            r_probe <= n_probe;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: a query outside the stamp reports zeros.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_attr_x     <= r_bad ? 6'd0 : r_x[5:0];
            r_attr_y     <= r_bad ? 6'd0 : r_y[5:0];
            r_step_count <= r_bad ? '0 : r_steps;
            r_bad_coord  <= r_bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_attr_x     = r_attr_x;
    assign o_attr_y     = r_attr_y;
    assign o_step_count = r_step_count;
    assign o_bad_coord  = r_bad_coord;

    // ---------------- assertions ----------------
    // The walk never leaves the configured stamp.
    a_walk_in_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_x < w_eff && r_y < h_eff))
        else $error("walk position outside the stamp");

    // A bad query reports zero coordinates and no moves.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_coord) |->
            (o_attr_x == 6'd0 && o_attr_y == 6'd0 && o_step_count == 12'd0))
        else $error("bad query result carries a coordinate");

    // Moves are counted only in the decide cycle.
    a_steps_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && $past(r_state) == S_PROBE) |->
            (r_steps == $past(r_steps)))
        else $error("step count changed while probing");

    // No move found ends the walk.
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && cmp_dir == pahc_pkg::PRB_CENTRE) |=> (r_state == S_DONE))
        else $error("walk did not stop at the local maximum");

endmodule
